FILE: src/bam_pkg.sv
// Shared types and constants for the bump allocator with marks.
package bam_pkg;

    localparam int SIZE_W   = 21;
    localparam int ALIGN_W  = 4;
    localparam int SLOT_W   = 4;
    localparam int CAP_W    = 21;
    localparam int RSP_OFS_W = 21;

    localparam logic [CAP_W-1:0] CAP_RESET = 21'd1048576;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_MARK    = 2'd1,
        ACT_RESTORE = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [SIZE_W-1:0]   request_size;
        logic [ALIGN_W-1:0]  align_log2;
        logic [SLOT_W-1:0]   mark_slot_in;
    } req_t;

    typedef struct packed {
        logic                 ok;
        logic [RSP_OFS_W-1:0] block_offset;
        logic [SLOT_W-1:0]    mark_slot_out;
    } rsp_t;

    typedef struct packed {
        logic [CAP_W-1:0] arena_capacity;
    } cfg_t;

endpackage

FILE: src/bam_chan_if.sv
// Valid/ready channel carrying one payload item per handshake.
interface bam_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

FILE: src/bump_allocator_with_marks.sv
// Bump allocator with a stack of saved offsets: top level.
// Channels:
//   req : item = action, request_size, align_log2, mark_slot_in (valid/ready).
//   rsp : item = ok, block_offset, mark_slot_out; exactly one per req item.
//   cfg : write of arena_capacity; always ready, write only while idle.
// Throughput: one item per cycle while rsp is not held. The request sits in one
// input register (the saved-offset memory is read into a register at the edge
// that loads it), then, once the result register is free, the align, add and
// capacity compare update the state and load the result register.
// Reset: offset and mark count go to zero, capacity to 1048576 (clipped to
// 2^OFFSET_BITS-1), both stages empty. Saved offsets are not cleared; only
// slots below the mark count are ever used.
// Stall: while rsp is held, the result register keeps its item, the input
// register keeps one more, and req.ready drops once both are full.
module bump_allocator_with_marks #(
    parameter int MAX_MARKS   = 16,
    parameter int OFFSET_BITS = 21
) (
    input  logic clk,
    input  logic rst_n,
    bam_chan_if.sink   req,
    bam_chan_if.source rsp,
    bam_chan_if.sink   cfg
);
    import bam_pkg::*;

    localparam int OB   = OFFSET_BITS;
    localparam int WW   = OB + 17;
    localparam int CW   = $clog2(MAX_MARKS + 1);
    localparam int AW   = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
    localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam logic [WW-1:0] OFS_MAX_W = (WW'(1) << OB) - WW'(1);

    function automatic logic [OB-1:0] fit_cap(input logic [CAP_W-1:0] raw);
        logic [WW-1:0] w;
        w = WW'(raw);
        if (w == '0)
        begin
            w = WW'(1);
        end
        if (w > OFS_MAX_W)
        begin
            w = OFS_MAX_W;
        end
        return OB'(w);
    endfunction

    logic [OB-1:0] cap_reg;
    logic [OB-1:0] offset_reg, offset_next;
    logic [CW-1:0] marks_reg, marks_next;
    logic          s_vld_reg;
    req_t          s_req_reg;
    logic          o_vld_reg;
    rsp_t          o_rsp_reg, o_rsp_next;

    logic          fire;
    logic          accept;
    logic          stk_wr;
    logic [OB-1:0] stk_rd_data;

    logic [WW-1:0] step_w;
    logic [WW-1:0] aligned_w;
    logic [WW-1:0] end_w;
    logic          alloc_fit;
    logic          mark_ok;
    logic          restore_ok;

    assign fire    = s_vld_reg && (!o_vld_reg || rsp.ready);
    assign req.ready = !s_vld_reg || fire;
    assign accept  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid   = o_vld_reg;
    assign rsp.payload = o_rsp_reg;

    always_comb
    begin
        step_w     = WW'(1) << s_req_reg.align_log2;
        aligned_w  = (WW'(offset_reg) + step_w - WW'(1)) & ~(step_w - WW'(1));
        end_w      = aligned_w + WW'(s_req_reg.request_size);
        alloc_fit  = (end_w <= WW'(cap_reg));
        mark_ok    = (marks_reg < CW'(MAX_MARKS));
        restore_ok = (CMPW'(s_req_reg.mark_slot_in) < CMPW'(marks_reg));
    end

    always_comb
    begin
        offset_next = offset_reg;
        marks_next  = marks_reg;
        stk_wr      = 1'b0;
        o_rsp_next  = '0;
        case (s_req_reg.action)
            ACT_ALLOC:
            begin
                if (alloc_fit)
                begin
                    o_rsp_next.ok           = 1'b1;
                    o_rsp_next.block_offset = RSP_OFS_W'(aligned_w);
                    offset_next             = OB'(end_w);
                end
            end
            ACT_MARK:
            begin
                if (mark_ok)
                begin
                    o_rsp_next.ok            = 1'b1;
                    o_rsp_next.mark_slot_out = SLOT_W'(marks_reg);
                    marks_next               = marks_reg + CW'(1);
                    stk_wr                   = fire;
                end
            end
            ACT_RESTORE:
            begin
                if (restore_ok)
                begin
                    o_rsp_next.ok = 1'b1;
                    offset_next   = stk_rd_data;
                    marks_next    = CW'(s_req_reg.mark_slot_in);
                end
            end
            ACT_CLEAR:
            begin
                o_rsp_next.ok = 1'b1;
                offset_next   = '0;
                marks_next    = '0;
            end
            default:
            begin
                o_rsp_next = '0;
            end
        endcase
    end

    bam_mark_stack #(
        .DEPTH (MAX_MARKS),
        .WIDTH (OB),
        .AW    (AW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr),
        .wr_addr (AW'(marks_reg)),
        .wr_data (offset_reg),
        .rd_en   (accept),
        .rd_addr (AW'(req.payload.mark_slot_in)),
        .rd_data (stk_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= fit_cap(CAP_RESET);
            offset_reg <= '0;
            marks_reg  <= '0;
            s_vld_reg  <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= fit_cap(cfg.payload.arena_capacity);
            end
            if (fire)
            begin
                offset_reg <= offset_next;
                marks_reg  <= marks_next;
            end
            if (req.ready)
            begin
                s_vld_reg <= req.valid;
            end
            if (fire)
            begin
                o_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                o_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_req_reg <= req.payload;
        end
        if (fire)
        begin
            o_rsp_reg <= o_rsp_next;
        end
    end

    a_marks_bound: assert property (@(posedge clk) disable iff (!rst_n)
        marks_reg <= CW'(MAX_MARKS))
        else $error("mark count above stack depth");

    a_fail_keeps_offset: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (s_req_reg.action == ACT_ALLOC) && !alloc_fit |=> $stable(offset_reg))
        else $error("failed alloc moved the offset");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (s_req_reg.action == ACT_CLEAR)
        |=> (offset_reg == '0) && (marks_reg == '0) && o_vld_reg && o_rsp_reg.ok)
        else $error("clear did not empty the arena");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (s_req_reg.action == ACT_MARK) && mark_ok
        |=> marks_reg == CW'($past(marks_reg) + CW'(1)))
        else $error("push did not advance the mark count");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> s_vld_reg && o_vld_reg && !rsp.ready)
        else $error("request stalled without a full pipe");
endmodule

FILE: src/bam_mark_stack.sv
// Saved-offset memory with registered read and write-to-read forwarding.
module bam_mark_stack #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 21,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a push retiring on the same edge as the read lands in the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
endmodule
